>>> rtl/pnu_pkg.sv
// ----------------------------------------------------------------------------
// pnu_pkg: shared types and helpers for the proof-number node update core
// Field widths, result codes, the child beat and the per-node snapshot that
// passes from the fold stage to the decision stage.
// ----------------------------------------------------------------------------
`default_nettype none

package pnu_pkg;

  localparam int NUM_W   = 32;
  localparam int DEPTH_W = 16;
  localparam int POS_W   = 5;

  localparam int MAX_CHILDREN_DEF = 32;

  localparam logic [NUM_W-1:0]   INF_RESET = '1;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

  // configuration register indexes
  localparam int unsigned REG_INFINITY = 0;

  typedef enum logic [1:0] {
    DEC_DESCEND   = 2'd0,
    DEC_RESOLVED  = 2'd1,
    DEC_THRESHOLD = 2'd2
  } pnu_decision_t;

  typedef enum logic [1:0] {
    OUT_UNKNOWN = 2'd0,
    OUT_WIN     = 2'd1,
    OUT_LOSS    = 2'd2,
    OUT_DRAW    = 2'd3
  } pnu_outcome_t;

  // seen flag bit positions
  localparam int SEEN_WIN  = 0;
  localparam int SEEN_LOSS = 1;
  localparam int SEEN_DRAW = 2;

  typedef struct packed {
    logic               node_is_or;
    logic [NUM_W-1:0]   pn;          // already clamped to infinity
    logic [NUM_W-1:0]   dn;          // already clamped to infinity
    pnu_outcome_t       outcome;
    logic [DEPTH_W-1:0] depth;
    logic [NUM_W-1:0]   th_pn;
    logic [NUM_W-1:0]   th_dn;
    logic               last;
  } pnu_child_t;

  typedef struct packed {
    logic               kind_or;
    logic [NUM_W-1:0]   pn;
    logic [NUM_W-1:0]   dn;
    logic [POS_W-1:0]   best_pos;
    logic [NUM_W-1:0]   second_val;
    logic [NUM_W-1:0]   best_cpn;
    logic [NUM_W-1:0]   best_cdn;
    logic [2:0]         seen;
    logic [DEPTH_W-1:0] win_min;
    logic [DEPTH_W-1:0] win_max;
    logic [DEPTH_W-1:0] draw_min;
    logic [DEPTH_W-1:0] loss_min;
    logic [DEPTH_W-1:0] loss_max;
    logic [NUM_W-1:0]   th_pn;
    logic [NUM_W-1:0]   th_dn;
  } pnu_snap_t;

  typedef struct packed {
    logic [NUM_W-1:0]   node_pn;
    logic [NUM_W-1:0]   node_dn;
    pnu_decision_t      decision;
    logic [POS_W-1:0]   best_index;
    logic [NUM_W-1:0]   second_best_value;
    logic [NUM_W-1:0]   child_th_pn;
    logic [NUM_W-1:0]   child_th_dn;
    pnu_outcome_t       outcome;
    logic [DEPTH_W-1:0] proof_depth;
  } pnu_result_t;

  function automatic logic [NUM_W-1:0] umin(input logic [NUM_W-1:0] a,
                                            input logic [NUM_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [NUM_W-1:0] sat_add(input logic [NUM_W-1:0] a,
                                               input logic [NUM_W-1:0] b,
                                               input logic [NUM_W-1:0] inf);
    logic [NUM_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return (sum > {1'b0, inf}) ? inf : sum[NUM_W-1:0];
  endfunction

  function automatic logic [DEPTH_W-1:0] depth_inc(input logic [DEPTH_W-1:0] d);
    return (d == DEPTH_MAX) ? DEPTH_MAX : d + 1'b1;
  endfunction

endpackage

`default_nettype wire

>>> rtl/pnu_fold.sv
// ----------------------------------------------------------------------------
// pnu_fold: per-node accumulator
// Folds one child beat per cycle into the running numbers, best and
// second-best values and per-outcome depth bounds; a last child waits for
// snapshot room, then hands a snapshot of the node to the decision stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pnu_fold import pnu_pkg::*; #(
  parameter int MAX_CHILDREN = MAX_CHILDREN_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [NUM_W-1:0] infinity,
  input  wire logic             child_valid,
  input  wire pnu_child_t       child,
  output logic                  child_take,
  output logic                  snap_valid,
  input  wire logic             snap_ready,
  output pnu_snap_t             snap
);

  localparam int CNT_W = $clog2(MAX_CHILDREN + 1);

  logic               node_open;
  logic               kind_or;
  logic [NUM_W-1:0]   run_pn, run_dn, best_val, second_val, best_cpn, best_cdn;
  logic [POS_W-1:0]   best_pos;
  logic [CNT_W-1:0]   count;
  logic [2:0]         seen;
  logic [DEPTH_W-1:0] win_min, win_max, draw_min, loss_min, loss_max;

  // state as seen by this beat: a fresh node starts from initial values
  logic               b_kind;
  logic [NUM_W-1:0]   b_pn, b_dn, b_best, b_second, b_cpn, b_cdn;
  logic [POS_W-1:0]   b_pos;
  logic [CNT_W-1:0]   b_count;
  logic [2:0]         b_seen;
  logic [DEPTH_W-1:0] b_win_min, b_win_max, b_draw_min, b_loss_min, b_loss_max;

  logic               fold_en;
  logic [NUM_W-1:0]   sel;
  logic [NUM_W-1:0]   run_pn_next, run_dn_next, best_val_next, second_val_next;
  logic [NUM_W-1:0]   best_cpn_next, best_cdn_next;
  logic [POS_W-1:0]   best_pos_next;
  logic [CNT_W-1:0]   count_next;
  logic [2:0]         seen_next;
  logic [DEPTH_W-1:0] win_min_next, win_max_next, draw_min_next;
  logic [DEPTH_W-1:0] loss_min_next, loss_max_next;
  logic               snap_free;

  always_comb begin
    b_kind     = node_open ? kind_or : child.node_is_or;
    b_pn       = node_open ? run_pn : (child.node_is_or ? infinity : '0);
    b_dn       = node_open ? run_dn : (child.node_is_or ? '0 : infinity);
    b_best     = node_open ? best_val : infinity;
    b_second   = node_open ? second_val : infinity;
    b_cpn      = node_open ? best_cpn : '0;
    b_cdn      = node_open ? best_cdn : '0;
    b_pos      = node_open ? best_pos : '0;
    b_count    = node_open ? count : '0;
    b_seen     = node_open ? seen : '0;
    b_win_min  = node_open ? win_min : DEPTH_MAX;
    b_win_max  = node_open ? win_max : '0;
    b_draw_min = node_open ? draw_min : DEPTH_MAX;
    b_loss_min = node_open ? loss_min : DEPTH_MAX;
    b_loss_max = node_open ? loss_max : '0;
  end

  always_comb begin
    fold_en         = b_count < CNT_W'(MAX_CHILDREN);
    sel             = b_kind ? child.pn : child.dn;
    run_pn_next     = b_pn;
    run_dn_next     = b_dn;
    best_val_next   = b_best;
    second_val_next = b_second;
    best_pos_next   = b_pos;
    best_cpn_next   = b_cpn;
    best_cdn_next   = b_cdn;
    count_next      = b_count;
    seen_next       = b_seen;
    win_min_next    = b_win_min;
    win_max_next    = b_win_max;
    draw_min_next   = b_draw_min;
    loss_min_next   = b_loss_min;
    loss_max_next   = b_loss_max;
    if (fold_en) begin
      if (b_kind) begin
        run_pn_next = umin(b_pn, child.pn);
        run_dn_next = sat_add(b_dn, child.dn, infinity);
      end else begin
        run_pn_next = sat_add(b_pn, child.pn, infinity);
        run_dn_next = umin(b_dn, child.dn);
      end
      // first strict minimum wins the best slot
      if (sel < b_best) begin
        second_val_next = b_best;
        best_val_next   = sel;
        best_pos_next   = POS_W'(b_count);
        best_cpn_next   = child.pn;
        best_cdn_next   = child.dn;
      end else if (sel < b_second) begin
        second_val_next = sel;
      end
      unique case (child.outcome)
        OUT_WIN: begin
          seen_next[SEEN_WIN] = 1'b1;
          if (child.depth < b_win_min) win_min_next = child.depth;
          if (child.depth > b_win_max) win_max_next = child.depth;
        end
        OUT_LOSS: begin
          seen_next[SEEN_LOSS] = 1'b1;
          if (child.depth < b_loss_min) loss_min_next = child.depth;
          if (child.depth > b_loss_max) loss_max_next = child.depth;
        end
        OUT_DRAW: begin
          seen_next[SEEN_DRAW] = 1'b1;
          if (child.depth < b_draw_min) draw_min_next = child.depth;
        end
        default: ;
      endcase
      count_next = b_count + 1'b1;
    end
  end

  assign snap_free  = !snap_valid || snap_ready;
  // a last child needs room in the snapshot register, others always go in
  assign child_take = child_valid && (!child.last || snap_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      node_open  <= 1'b0;
      snap_valid <= 1'b0;
    end else begin
      if (child_take) node_open <= !child.last;
      snap_valid <= (snap_valid && !snap_ready) || (child_take && child.last);
    end
  end

  always_ff @(posedge clk) begin
    if (child_take) begin
      kind_or    <= b_kind;
      run_pn     <= run_pn_next;
      run_dn     <= run_dn_next;
      best_val   <= best_val_next;
      second_val <= second_val_next;
      best_pos   <= best_pos_next;
      best_cpn   <= best_cpn_next;
      best_cdn   <= best_cdn_next;
      count      <= count_next;
      seen       <= seen_next;
      win_min    <= win_min_next;
      win_max    <= win_max_next;
      draw_min   <= draw_min_next;
      loss_min   <= loss_min_next;
      loss_max   <= loss_max_next;
    end
    if (child_take && child.last) begin
      snap.kind_or    <= b_kind;
      snap.pn         <= run_pn_next;
      snap.dn         <= run_dn_next;
      snap.best_pos   <= best_pos_next;
      snap.second_val <= second_val_next;
      snap.best_cpn   <= best_cpn_next;
      snap.best_cdn   <= best_cdn_next;
      snap.seen       <= seen_next;
      snap.win_min    <= win_min_next;
      snap.win_max    <= win_max_next;
      snap.draw_min   <= draw_min_next;
      snap.loss_min   <= loss_min_next;
      snap.loss_max   <= loss_max_next;
      snap.th_pn      <= child.th_pn;
      snap.th_dn      <= child.th_dn;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pnu_decide.sv
// ----------------------------------------------------------------------------
// pnu_decide: node decision and result register
// Turns a folded node into resolved, threshold reached or descend with
// child thresholds, and holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module pnu_decide import pnu_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [NUM_W-1:0] infinity,
  input  wire logic             snap_valid,
  input  wire pnu_snap_t        snap,
  output logic                  snap_ready,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output pnu_result_t           result
);

  pnu_result_t        res;
  logic [NUM_W-1:0]   sel_th, oth_th, oth_run, oth_best, sel_lim, oth_lim;
  logic [NUM_W:0]     sec_inc;
  logic [NUM_W+1:0]   t_sum, t_cap, t_val;

  always_comb begin
    // selecting side follows the node kind, the other side gets the slack
    sel_th   = snap.kind_or ? snap.th_pn : snap.th_dn;
    oth_th   = snap.kind_or ? snap.th_dn : snap.th_pn;
    oth_run  = snap.kind_or ? snap.dn : snap.pn;
    oth_best = snap.kind_or ? snap.best_cdn : snap.best_cpn;

    sec_inc = {1'b0, snap.second_val} + 1'b1;
    if (snap.second_val >= infinity) sel_lim = sel_th;
    else if (sec_inc < {1'b0, sel_th}) sel_lim = sec_inc[NUM_W-1:0];
    else sel_lim = sel_th;

    // th - run + best, capped at infinity; compare against run + infinity
    t_sum = {2'b00, oth_th} + {2'b00, oth_best};
    t_cap = {2'b00, oth_run} + {2'b00, infinity};
    t_val = t_sum - {2'b00, oth_run};
    if (oth_th >= infinity) oth_lim = infinity;
    else if (t_sum > t_cap) oth_lim = infinity;
    else oth_lim = t_val[NUM_W-1:0];

    res.node_pn           = snap.pn;
    res.node_dn           = snap.dn;
    res.best_index        = snap.best_pos;
    res.second_best_value = snap.second_val;
    res.child_th_pn       = '0;
    res.child_th_dn       = '0;
    res.outcome           = OUT_UNKNOWN;
    res.proof_depth       = '0;

    priority if (snap.pn == '0 || snap.dn == '0) begin
      res.decision = DEC_RESOLVED;
      priority if (snap.pn == '0) begin
        res.outcome     = OUT_WIN;
        res.proof_depth = depth_inc(snap.kind_or ? snap.win_min : snap.win_max);
      end else if (snap.kind_or) begin
        if (snap.seen[SEEN_DRAW]) begin
          res.outcome     = OUT_DRAW;
          res.proof_depth = depth_inc(snap.draw_min);
        end else begin
          res.outcome     = OUT_LOSS;
          res.proof_depth = depth_inc(snap.loss_max);
        end
      end else begin
        if (snap.seen[SEEN_LOSS]) begin
          res.outcome     = OUT_LOSS;
          res.proof_depth = depth_inc(snap.loss_min);
        end else begin
          res.outcome     = OUT_DRAW;
          res.proof_depth = depth_inc(snap.draw_min);
        end
      end
    end else if (snap.pn >= snap.th_pn || snap.dn >= snap.th_dn) begin
      res.decision = DEC_THRESHOLD;
    end else begin
      res.decision    = DEC_DESCEND;
      res.child_th_pn = snap.kind_or ? sel_lim : oth_lim;
      res.child_th_dn = snap.kind_or ? oth_lim : sel_lim;
    end
  end

  assign snap_ready = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (result_valid && !result_ready) || (snap_valid && snap_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && snap_ready) result <= res;
  end

  a_resolved_has_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.decision == DEC_RESOLVED
      |-> result.node_pn == '0 || result.node_dn == '0)
    else $error("resolved node with nonzero proof and disproof");

  a_th_only_on_descend: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.decision != DEC_DESCEND
      |-> result.child_th_pn == '0 && result.child_th_dn == '0)
    else $error("child thresholds set outside descend");

  a_outcome_only_resolved: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.decision != DEC_RESOLVED
      |-> result.outcome == OUT_UNKNOWN && result.proof_depth == '0)
    else $error("outcome set on unresolved node");

  a_depth_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.decision == DEC_RESOLVED |-> result.proof_depth != '0)
    else $error("resolved node with zero proof depth");

endmodule

`default_nettype wire

>>> rtl/proof_number_node_update_core.sv
// ----------------------------------------------------------------------------
// proof_number_node_update_core: proof-number search node update
// Streams child records of one node and emits the node decision.
// ----------------------------------------------------------------------------
// Usage:
//   Child channel (child_valid/child_ready): one beat per child record of a
//   node; the beat with last_child set closes the node and carries the node
//   thresholds. Node kind is taken from the first beat of a node.
//   Result channel (result_valid/result_ready): one beat per node.
//   Path: a last-child beat goes through the input register, the fold
//   snapshot and the decision register before it shows on the result channel.
//   Throughput: one child beat per cycle, also across node boundaries, except
//   while a last-child beat waits for room in the snapshot register; the fold
//   of each child is a compare and a saturating add, and it sets the rate.
//   A stalled result holds in the output register; children keep streaming
//   in while a second closed node waits behind it, until the next last-child
//   beat holds in the input register and child_ready drops.
//   Reset: no node open, pipeline empty, infinity_value = 0xFFFFFFFF.
//   APB register 0 (byte address 0): infinity_value; write only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module proof_number_node_update_core import pnu_pkg::*; #(
  parameter int MAX_CHILDREN = MAX_CHILDREN_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // APB configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  // child records
  input  wire logic               child_valid,
  output logic                    child_ready,
  input  wire logic               node_is_or,
  input  wire logic [NUM_W-1:0]   child_pn,
  input  wire logic [NUM_W-1:0]   child_dn,
  input  wire logic [1:0]         child_outcome,
  input  wire logic [DEPTH_W-1:0] child_depth,
  input  wire logic [NUM_W-1:0]   parent_th_pn,
  input  wire logic [NUM_W-1:0]   parent_th_dn,
  input  wire logic               last_child,
  // node results
  output logic                    result_valid,
  input  wire logic               result_ready,
  output logic [NUM_W-1:0]        node_pn,
  output logic [NUM_W-1:0]        node_dn,
  output logic [1:0]              decision,
  output logic [POS_W-1:0]        best_index,
  output logic [NUM_W-1:0]        second_best_value,
  output logic [NUM_W-1:0]        child_th_pn,
  output logic [NUM_W-1:0]        child_th_dn,
  output logic [1:0]              outcome,
  output logic [DEPTH_W-1:0]      proof_depth
);

  logic [NUM_W-1:0] infinity;
  logic             child_q_valid;
  pnu_child_t       child_q;
  logic             fold_take;
  logic             snap_valid, snap_ready;
  pnu_snap_t        snap;
  pnu_result_t      result;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2] == 1'(REG_INFINITY);
  assign prdata  = reg_sel ? infinity : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      infinity <= INF_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      infinity <= pwdata;
    end
  end

  // input register; clamp the child numbers on the way in
  assign child_ready = !child_q_valid || fold_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      child_q_valid <= 1'b0;
    end else if (child_ready) begin
      child_q_valid <= child_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (child_valid && child_ready) begin
      child_q.node_is_or <= node_is_or;
      child_q.pn         <= umin(child_pn, infinity);
      child_q.dn         <= umin(child_dn, infinity);
      child_q.outcome    <= pnu_outcome_t'(child_outcome);
      child_q.depth      <= child_depth;
      child_q.th_pn      <= parent_th_pn;
      child_q.th_dn      <= parent_th_dn;
      child_q.last       <= last_child;
    end
  end

  pnu_fold #(
    .MAX_CHILDREN (MAX_CHILDREN)
  ) u_fold (
    .clk         (clk),
    .rst         (rst),
    .infinity    (infinity),
    .child_valid (child_q_valid),
    .child       (child_q),
    .child_take  (fold_take),
    .snap_valid  (snap_valid),
    .snap_ready  (snap_ready),
    .snap        (snap)
  );

  pnu_decide u_decide (
    .clk          (clk),
    .rst          (rst),
    .infinity     (infinity),
    .snap_valid   (snap_valid),
    .snap         (snap),
    .snap_ready   (snap_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  assign node_pn           = result.node_pn;
  assign node_dn           = result.node_dn;
  assign decision          = result.decision;
  assign best_index        = result.best_index;
  assign second_best_value = result.second_best_value;
  assign child_th_pn       = result.child_th_pn;
  assign child_th_dn       = result.child_th_dn;
  assign outcome           = result.outcome;
  assign proof_depth       = result.proof_depth;

  a_accept_loads_q: assert property (@(posedge clk) disable iff (rst)
    child_valid && child_ready |=> child_q_valid)
    else $error("accepted child beat lost before fold stage");

  a_snap_needs_last: assert property (@(posedge clk) disable iff (rst)
    $rose(snap_valid) |-> $past(child_q_valid && child_q.last))
    else $error("snapshot raised without a last child");

endmodule

`default_nettype wire
